>>> hw/rtl/vfdp_pkg.sv
// Package with widths and pipeline types for the vsync frame deadline predictor.
package vfdp_pkg;
    localparam int DURATION_BITS = 32;
    localparam int TIME_BITS = 62;
    localparam int OUT_BITS = TIME_BITS + 1;
    localparam int NUM_CELLS = OUT_BITS;

    typedef logic [TIME_BITS-1:0] t_time;
    typedef logic [OUT_BITS-1:0] t_wide;
    typedef logic [DURATION_BITS-1:0] t_dur;

    typedef struct packed {
        logic  valid;
        logic  hit;
        logic  zero;
        t_wide dividend;
        t_dur  rem;
        t_dur  period;
        t_dur  prep;
        t_time anchor;
        t_wide earliest;
    } t_cell_data;
endpackage

>>> hw/rtl/vfdp_if.sv
// Handshake interfaces for the request and result channels.
interface vfdp_req_if;
    logic                 valid;
    logic                 ready;
    vfdp_pkg::t_time      now_time;
    vfdp_pkg::t_time      requested_time;
    vfdp_pkg::t_time      last_vsync;
    vfdp_pkg::t_dur       vsync_period;
    vfdp_pkg::t_dur       prep_duration;
    modport source (output valid, now_time, requested_time, last_vsync, vsync_period,
                    prep_duration, input ready);
    modport sink (input valid, now_time, requested_time, last_vsync, vsync_period,
                  prep_duration, output ready);
endinterface

interface vfdp_res_if;
    logic                 valid;
    logic                 ready;
    vfdp_pkg::t_wide      latch_time;
    vfdp_pkg::t_wide      target_time;
    modport source (output valid, latch_time, target_time, input ready);
    modport sink (input valid, latch_time, target_time, output ready);
endinterface

>>> hw/rtl/vsync_frame_deadline_predictor.sv
// Top level of the vsync frame deadline predictor.
// A request is taken every cycle unless the result register is full and not taken; the
// whole pipeline then stalls together. Each request returns exactly one result, passing
// through two front stages, 63 one-bit division cells that find the remainder of the
// offset from the last vsync, and one output register that rounds onto the grid.
module vsync_frame_deadline_predictor (
    input  logic         i_clk,
    input  logic         i_rst_n,
    vfdp_req_if.sink     i_req,
    vfdp_res_if.source   o_res
);
    logic                 w_en;
    vfdp_pkg::t_cell_data w_chain [vfdp_pkg::NUM_CELLS+1];

    assign w_en = !o_res.valid || o_res.ready;
    assign i_req.ready = w_en;

    vfdp_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_en             (w_en),
        .i_valid          (i_req.valid),
        .i_now_time       (i_req.now_time),
        .i_requested_time (i_req.requested_time),
        .i_last_vsync     (i_req.last_vsync),
        .i_vsync_period   (i_req.vsync_period),
        .i_prep_duration  (i_req.prep_duration),
        .o_d              (w_chain[0])
    );

    for (genvar g = 0; g < vfdp_pkg::NUM_CELLS; g++) begin : g_cell
        vfdp_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_d     (w_chain[g]),
            .o_d     (w_chain[g+1])
        );
    end

    vfdp_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (w_en),
        .i_d           (w_chain[vfdp_pkg::NUM_CELLS]),
        .o_valid       (o_res.valid),
        .o_latch_time  (o_res.latch_time),
        .o_target_time (o_res.target_time)
    );

`ifndef NO_ASSERTIONS
    a_target_not_below_latch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> o_res.target_time >= o_res.latch_time)
        else $error("target below latch time");

    a_stall_holds_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && !o_res.ready |=> o_res.valid && $stable(o_res.target_time))
        else $error("stalled result changed");

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_res.valid)
        else $error("result valid after reset");
`endif
endmodule

>>> hw/rtl/vfdp_front.sv
// Front stages: sums, earliest acceptable time and grid offset.
module vfdp_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  vfdp_pkg::t_time       i_now_time,
    input  vfdp_pkg::t_time       i_requested_time,
    input  vfdp_pkg::t_time       i_last_vsync,
    input  vfdp_pkg::t_dur        i_vsync_period,
    input  vfdp_pkg::t_dur        i_prep_duration,
    output vfdp_pkg::t_cell_data  o_d
);
    logic                r_valid_a;
    vfdp_pkg::t_wide     r_now_prep;
    vfdp_pkg::t_wide     r_half;
    vfdp_pkg::t_time     r_req;
    vfdp_pkg::t_time     r_anchor;
    vfdp_pkg::t_dur      r_period;
    vfdp_pkg::t_dur      r_prep;
    vfdp_pkg::t_cell_data r_d;
    vfdp_pkg::t_cell_data n_d;
    vfdp_pkg::t_wide     w_max;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_a <= 1'b0;
            r_d.valid <= 1'b0;
        end else if (i_en) begin
            r_valid_a  <= i_valid;
            r_now_prep <= {1'b0, i_now_time} +
                          vfdp_pkg::OUT_BITS'(i_prep_duration);
            r_half     <= {1'b0, i_last_vsync} +
                          vfdp_pkg::OUT_BITS'(i_vsync_period >> 1);
            r_req      <= i_requested_time;
            r_anchor   <= i_last_vsync;
            r_period   <= i_vsync_period;
            r_prep     <= i_prep_duration;
            r_d        <= n_d;
        end
    end

    always_comb begin
        w_max = (r_half > r_now_prep) ? r_half : r_now_prep;
        n_d.valid    = r_valid_a;
        n_d.earliest = (w_max > {1'b0, r_req}) ? w_max : {1'b0, r_req};
        n_d.hit      = {1'b0, r_anchor} >= n_d.earliest;
        n_d.zero     = (r_period == '0);
        n_d.dividend = n_d.earliest - {1'b0, r_anchor};
        n_d.rem      = '0;
        n_d.period   = r_period;
        n_d.prep     = r_prep;
        n_d.anchor   = r_anchor;
    end

    assign o_d = r_d;
endmodule

>>> hw/rtl/vfdp_cell.sv
// One restoring division cell: takes one dividend bit into the partial remainder.
module vfdp_cell (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  vfdp_pkg::t_cell_data  i_d,
    output vfdp_pkg::t_cell_data  o_d
);
    vfdp_pkg::t_cell_data r_d;
    vfdp_pkg::t_cell_data n_d;
    logic [vfdp_pkg::DURATION_BITS:0] w_trial;

    always_comb begin
        n_d = i_d;
        w_trial = {i_d.rem, i_d.dividend[vfdp_pkg::OUT_BITS-1]};
        if (w_trial >= {1'b0, i_d.period}) begin
            w_trial = w_trial - {1'b0, i_d.period};
        end
        n_d.rem = w_trial[vfdp_pkg::DURATION_BITS-1:0];
        n_d.dividend = {i_d.dividend[vfdp_pkg::OUT_BITS-2:0], 1'b0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d.valid <= 1'b0;
        end else if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;
endmodule

>>> hw/rtl/vfdp_back.sv
// Back stage: rounds up onto the grid from the remainder and holds the result.
module vfdp_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  vfdp_pkg::t_cell_data  i_d,
    output logic                  o_valid,
    output vfdp_pkg::t_wide       o_latch_time,
    output vfdp_pkg::t_wide       o_target_time
);
    logic            r_valid;
    vfdp_pkg::t_wide r_latch;
    vfdp_pkg::t_wide r_target;
    vfdp_pkg::t_wide n_target;

    always_comb begin
        if (i_d.hit) begin
            n_target = {1'b0, i_d.anchor};
        end else if (i_d.zero || i_d.rem == '0) begin
            n_target = i_d.earliest;
        end else begin
            // Step back to the grid point below, then forward one period.
            n_target = i_d.earliest - vfdp_pkg::OUT_BITS'(i_d.rem) +
                       vfdp_pkg::OUT_BITS'(i_d.period);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid  <= i_d.valid;
            r_target <= n_target;
            r_latch  <= n_target - vfdp_pkg::OUT_BITS'(i_d.prep);
        end
    end

    assign o_valid       = r_valid;
    assign o_latch_time  = r_latch;
    assign o_target_time = r_target;
endmodule

>>> tb/sv/vfdp_tb_if.sv
// Helper types for the testbench checker.
package vfdp_tb_pkg;
    typedef struct packed {
        vfdp_pkg::t_wide latch_time;
        vfdp_pkg::t_wide target_time;
    } t_deadline;
endpackage

>>> tb/sv/vfdp_checker.sv
// Checker that predicts each deadline from the request transfers and compares the results.
module vfdp_checker (
    input  logic   i_clk,
    input  logic   i_rst_n,
    vfdp_req_if    req,
    vfdp_res_if    res,
    output int     o_errors,
    output int     o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    vfdp_tb_pkg::t_deadline deadline_q[$];

    function automatic vfdp_tb_pkg::t_deadline predict_deadline(
        vfdp_pkg::t_time now, vfdp_pkg::t_time want, vfdp_pkg::t_time anchor,
        vfdp_pkg::t_dur period, vfdp_pkg::t_dur prep);
        logic [63:0] earliest;
        logic [63:0] target;
        logic [63:0] offset;
        logic [63:0] rem;
        vfdp_tb_pkg::t_deadline d;
        earliest = 64'(anchor) + 64'(period >> 1);
        if (64'(now) + 64'(prep) > earliest) earliest = 64'(now) + 64'(prep);
        if (64'(want) > earliest) earliest = 64'(want);
        if (64'(anchor) >= earliest) begin
            target = 64'(anchor);
        end else if (period == '0) begin
            target = earliest;
        end else begin
            offset = earliest - 64'(anchor);
            rem = offset % 64'(period);
            target = (rem == 0) ? earliest : earliest - rem + 64'(period);
        end
        d.target_time = vfdp_pkg::t_wide'(target);
        d.latch_time = vfdp_pkg::t_wide'(target - 64'(prep));
        return d;
    endfunction

    always @(posedge i_clk) begin
        vfdp_tb_pkg::t_deadline exp_d;
        int err;
        err = 0;
        if (!i_rst_n) begin
            o_errors <= 0;
        end else begin
            if (req.valid && req.ready) begin
                deadline_q.push_back(predict_deadline(req.now_time, req.requested_time,
                    req.last_vsync, req.vsync_period, req.prep_duration));
            end
            if (res.valid && res.ready) begin
                if (deadline_q.size() == 0) begin
                    $display("%0t: result with no request pending: latch %0d target %0d",
                             $time, res.latch_time, res.target_time);
                    err++;
                end else begin
                    exp_d = deadline_q.pop_front();
                    if (exp_d.latch_time !== res.latch_time) begin
                        $display("%0t: latch_time expected %0d actual %0d",
                                 $time, exp_d.latch_time, res.latch_time);
                        err++;
                    end
                    if (exp_d.target_time !== res.target_time) begin
                        $display("%0t: target_time expected %0d actual %0d",
                                 $time, exp_d.target_time, res.target_time);
                        err++;
                    end
                end
            end
            o_errors <= o_errors + err;
        end
        o_pending <= deadline_q.size();
    end
endmodule

>>> tb/sv/tb.sv
// Top of the testbench: clock, reset, request stimulus, result back-pressure and verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY = 66;
    localparam int NUM_RANDOM = 450;
    localparam int HOLD_CYCLES = 200;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   errors;
    int   pending;
    bit   stim_done = 1'b0;
    bit   quiet = 1'b0;
    bit   hold_res = 1'b0;

    vfdp_req_if req ();
    vfdp_res_if res ();

    vsync_frame_deadline_predictor u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req),
        .o_res  (res)
    );

    vfdp_checker u_checker (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .req      (req),
        .res      (res),
        .o_errors (errors),
        .o_pending(pending)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic vfdp_pkg::t_time rand_time();
        return vfdp_pkg::t_time'({$urandom, $urandom});
    endfunction

    // Keeps the sums inside 63 bits by limiting times to 61 bits.
    function automatic vfdp_pkg::t_time rand_safe_time();
        case ($urandom_range(3))
            0: return vfdp_pkg::t_time'($urandom_range(1000));
            1: return vfdp_pkg::t_time'({$urandom, $urandom}) >> 1;
            2: return {1'b0, {(vfdp_pkg::TIME_BITS-1){1'b1}}} -
                      vfdp_pkg::t_time'($urandom_range(100));
            default: return vfdp_pkg::t_time'({$urandom_range(255), $urandom});
        endcase
    endfunction

    function automatic vfdp_pkg::t_dur rand_dur();
        case ($urandom_range(3))
            0: return vfdp_pkg::t_dur'($urandom_range(20));
            1: return '1 - vfdp_pkg::t_dur'($urandom_range(3));
            2: return vfdp_pkg::t_dur'($urandom_range(16666667, 8333333));
            default: return vfdp_pkg::t_dur'($urandom);
        endcase
    endfunction

    task automatic send_request(vfdp_pkg::t_time now, vfdp_pkg::t_time want,
                                vfdp_pkg::t_time anchor, vfdp_pkg::t_dur period,
                                vfdp_pkg::t_dur prep);
        while (!quiet && $urandom_range(99) < 38) begin
            req.valid <= 1'b0;
            @(posedge i_clk);
        end
        req.valid <= 1'b1;
        req.now_time <= now;
        req.requested_time <= want;
        req.last_vsync <= anchor;
        req.vsync_period <= period;
        req.prep_duration <= prep;
        @(posedge i_clk);
        while (!req.ready) @(posedge i_clk);
    endtask

    // A long hold-off early on lets the pipeline fill and stall the request side.
    initial begin
        int i;
        @(posedge i_clk iff i_rst_n);
        repeat (30) @(posedge i_clk);
        hold_res = 1'b1;
        for (i = 0; i < HOLD_CYCLES; i++) @(posedge i_clk);
        hold_res = 1'b0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || hold_res) res.ready <= 1'b0;
        else res.ready <= quiet || ($urandom_range(99) >= 38);
    end

    initial begin
        vfdp_pkg::t_time anchor;
        vfdp_pkg::t_dur  period;
        int              k;
        req.valid = 1'b0;
        req.now_time = '0;
        req.requested_time = '0;
        req.last_vsync = '0;
        req.vsync_period = '0;
        req.prep_duration = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // Directed: field extremes, zero period, anchor already late, exact grid hit.
        send_request('0, '0, '0, '0, '0);
        send_request('0, '0, '0, 32'd1, '0);
        send_request('1, '1, '1, '1, '1);
        send_request('1, '0, '0, '1, '1);
        send_request(62'd100, 62'd50, 62'd10, '0, 32'd5);
        send_request(62'd5, 62'd7, 62'd1000, 32'd10, 32'd3);
        send_request(62'd0, 62'd130, 62'd100, 32'd10, 32'd0);
        send_request(62'd0, 62'd131, 62'd100, 32'd10, 32'd0);
        send_request(62'd120, 62'd0, 62'd100, 32'd10, 32'd10);
        send_request(62'd0, 62'd0, 62'd100, 32'd20, 32'd0);
        send_request(62'd0, 62'd0, 62'd100, 32'd1, 32'd0);
        send_request({1'b0, {61{1'b1}}}, '0, '0, 32'd7, '1);
        send_request('0, '1, {1'b0, {61{1'b1}}}, '1, '0);
        send_request(62'h2AAA_AAAA_AAAA_AAAA, 62'h1555_5555_5555_5555, 62'h2AAA_AAAA_0000_0000,
                     32'hAAAA_AAAA, 32'h5555_5555);
        send_request(rand_time(), rand_time(), rand_time(), 32'h8000_0000, 32'h8000_0000);
        for (k = 0; k < NUM_RANDOM; k++) begin
            if (k == 200) quiet = 1'b1;
            if (k == 260) quiet = 1'b0;
            if ($urandom_range(9) == 0) begin
                send_request(rand_time(), rand_time(), rand_time(),
                             vfdp_pkg::t_dur'($urandom), vfdp_pkg::t_dur'($urandom));
            end else begin
                anchor = rand_safe_time();
                period = rand_dur();
                send_request(anchor + vfdp_pkg::t_time'($urandom_range(3 * (period + 1))),
                             ($urandom_range(1)) ?
                                 anchor + vfdp_pkg::t_time'(period * $urandom_range(4)) :
                                 rand_safe_time(),
                             anchor, period, rand_dur());
            end
        end
        req.valid <= 1'b0;
        stim_done = 1'b1;
    end

    initial begin
        wait (stim_done);
        // Let the checker record the last request transfer before the pending count is read.
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (errors == 0) begin
            $display("[vsync_frame_deadline_predictor] OK");
        end else begin
            $display("[vsync_frame_deadline_predictor] ERROR");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("[vsync_frame_deadline_predictor] ERROR");
        $finish;
    end
endmodule
